/* rtl/core/int64_to_ascii_hex_or_decimal_unit_macros.svh */
// assertion macros for the binary to ascii text converter
`ifndef INT64_TO_ASCII_HEX_OR_DECIMAL_UNIT_MACROS_SVH
`define INT64_TO_ASCII_HEX_OR_DECIMAL_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define I2A_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define I2A_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define I2A_ASSERT(lbl, prop, msg)
`define I2A_ASSERT_RST(lbl, prop, msg)
`endif

`endif

/* rtl/core/i2a_pkg.sv */
// package with types, constants and helpers of the binary to ascii text converter
package i2a_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int DEC_DIGITS  = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int HEX_DIGITS  = (VALUE_WIDTH + 3) / 4;
    localparam int HEX_PAD_W   = HEX_DIGITS * 4;
    localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
    localparam int REM_W       = $clog2(DEC_DIGITS + 1);

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [3:0] DEC_BASE = 4'd10;

    localparam logic REQ_DEC = 1'b0;
    localparam logic REQ_HEX = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [63:0] value;
    } in_item_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic conv;
        logic shift;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_EMIT
    } state_t;

    function automatic logic [7:0] digit_to_ascii(input logic [3:0] d);
        logic [7:0] code;
        if (d < DEC_BASE)
        begin
            code = CH_ZERO + {4'd0, d};
        end
        else
        begin
            code = CH_A + {4'd0, d} - {4'd0, DEC_BASE};
        end
        return code;
    endfunction

endpackage

/* rtl/core/int64_to_ascii_hex_or_decimal_unit.sv */
// top level: converts one value to decimal or hex ascii text, one character per transaction
// decimal: load, then a shift-add-3 conversion step per value bit through the digit cells, a '-' sign
//   if negative, then a scan of the 20 digit positions with leading zeros skipped
// hex: nibbles load straight into the cells, then the same scan of the 20 positions
// a new value is taken only in idle, once the last character of the previous one is pushed out
// reset clears the control state and output valid; the digit cells are not reset
`include "int64_to_ascii_hex_or_decimal_unit_macros.svh"

module int64_to_ascii_hex_or_decimal_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  i2a_pkg::in_item_t  item,
    output logic               text_valid,
    input  logic               text_ready,
    output i2a_pkg::out_item_t text
);

    localparam int W = i2a_pkg::VALUE_WIDTH;
    localparam int N = i2a_pkg::DEC_DIGITS;

    i2a_pkg::state_t            state_reg, state_next;
    logic [W-1:0]               shreg_reg, shreg_next;
    logic [i2a_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [i2a_pkg::REM_W-1:0]  rem_reg, rem_next;
    logic                       neg_reg, neg_next;
    logic                       skip_reg, skip_next;
    logic                       out_valid_reg, out_valid_next;
    i2a_pkg::out_item_t         text_reg, text_next;

    i2a_pkg::cell_ctrl_t        ctrl;
    logic [W-1:0]               v;
    logic [W-1:0]               v_neg;
    logic                       is_neg;
    logic [i2a_pkg::HEX_PAD_W-1:0] hex_pad;
    logic [3:0]                 digit_w [N];
    logic                       bit_w [N];
    logic [3:0]                 top_digit;
    logic                       can_push;
    logic                       push;
    logic                       accept;

    assign v       = item.value[W-1:0];
    assign v_neg   = ~v + {{(W-1){1'b0}}, 1'b1};
    assign is_neg  = (item.req_type == i2a_pkg::REQ_DEC) && v[W-1];
    assign hex_pad = i2a_pkg::HEX_PAD_W'(v);
    assign top_digit = digit_w[N-1];

    assign item_ready = (state_reg == i2a_pkg::ST_IDLE);
    assign accept     = item_valid && item_ready;
    assign can_push   = !out_valid_reg || text_ready;

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_cell
            logic [3:0] load_d;
            logic       b_in;
            logic [3:0] d_in;
            if (i < i2a_pkg::HEX_DIGITS)
            begin : g_hex
                assign load_d = (item.req_type == i2a_pkg::REQ_HEX) ? hex_pad[4*i +: 4] : 4'd0;
            end
            else
            begin : g_pad
                assign load_d = 4'd0;
            end
            if (i == 0)
            begin : g_first
                assign b_in = shreg_reg[W-1];
                assign d_in = 4'd0;
            end
            else
            begin : g_rest
                assign b_in = bit_w[i-1];
                assign d_in = digit_w[i-1];
            end
            i2a_bcd_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .load_digit (load_d),
                .bit_in     (b_in),
                .digit_in   (d_in),
                .digit      (digit_w[i]),
                .bit_out    (bit_w[i])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        shreg_next     = shreg_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        neg_next       = neg_reg;
        skip_next      = skip_reg;
        text_next      = text_reg;
        ctrl           = '0;
        push           = 1'b0;
        case (state_reg)
            i2a_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    ctrl.load  = 1'b1;
                    shreg_next = is_neg ? v_neg : v;
                    cnt_next   = i2a_pkg::CNT_W'(W);
                    rem_next   = i2a_pkg::REM_W'(N);
                    neg_next   = is_neg;
                    skip_next  = 1'b1;
                    state_next = (item.req_type == i2a_pkg::REQ_HEX) ?
                                 i2a_pkg::ST_EMIT : i2a_pkg::ST_CONV;
                end
            end
            i2a_pkg::ST_CONV:
            begin
                ctrl.conv  = 1'b1;
                shreg_next = {shreg_reg[W-2:0], 1'b0};
                cnt_next   = cnt_reg - 1'b1;
                if (cnt_reg == i2a_pkg::CNT_W'(1))
                begin
                    state_next = neg_reg ? i2a_pkg::ST_SIGN : i2a_pkg::ST_EMIT;
                end
            end
            i2a_pkg::ST_SIGN:
            begin
                if (can_push)
                begin
                    push                = 1'b1;
                    text_next.char_code = i2a_pkg::CH_MINUS;
                    text_next.last      = 1'b0;
                    state_next          = i2a_pkg::ST_EMIT;
                end
            end
            i2a_pkg::ST_EMIT:
            begin
                if (skip_reg && (top_digit == 4'd0) && (rem_reg != i2a_pkg::REM_W'(1)))
                begin
                    ctrl.shift = 1'b1;
                    rem_next   = rem_reg - 1'b1;
                end
                else if (can_push)
                begin
                    push                = 1'b1;
                    ctrl.shift          = 1'b1;
                    text_next.char_code = i2a_pkg::digit_to_ascii(top_digit);
                    text_next.last      = (rem_reg == i2a_pkg::REM_W'(1));
                    rem_next            = rem_reg - 1'b1;
                    skip_next           = 1'b0;
                    if (rem_reg == i2a_pkg::REM_W'(1))
                    begin
                        state_next = i2a_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = i2a_pkg::ST_IDLE;
            end
        endcase
        out_valid_next = push ? 1'b1 : (text_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= i2a_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            neg_reg       <= 1'b0;
            skip_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            rem_reg       <= rem_next;
            neg_reg       <= neg_next;
            skip_reg      <= skip_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shreg_reg <= shreg_next;
        text_reg  <= text_next;
    end

    assign text_valid = out_valid_reg;
    assign text       = text_reg;

    `I2A_ASSERT(a_conv_cnt, (state_reg == i2a_pkg::ST_CONV) |-> (cnt_reg != '0), "conversion count ran out")
    `I2A_ASSERT(a_conv_room, (state_reg == i2a_pkg::ST_CONV) |-> !bit_w[N-1], "digit chain overflow")
    `I2A_ASSERT(a_emit_rem, (state_reg == i2a_pkg::ST_EMIT) |-> (rem_reg != '0), "scan past last digit")
    `I2A_ASSERT(a_last_idle, (push && text_next.last) |=> (state_reg == i2a_pkg::ST_IDLE), "not idle after last")
    `I2A_ASSERT(a_hex_start, (accept && item.req_type == i2a_pkg::REQ_HEX) |=> (state_reg == i2a_pkg::ST_EMIT && !neg_reg), "hex start wrong")
    `I2A_ASSERT_RST(a_rst_idle, !rst_n |-> !text_valid, "output valid during reset")

endmodule

/* rtl/core/i2a_bcd_cell.sv */
// one digit cell: shift-add-3 step, parallel load and digit shift toward the top
module i2a_bcd_cell (
    input  logic              clk,
    input  i2a_pkg::cell_ctrl_t ctrl,
    input  logic [3:0]        load_digit,
    input  logic              bit_in,
    input  logic [3:0]        digit_in,
    output logic [3:0]        digit,
    output logic              bit_out
);

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj;

    always_comb
    begin
        adj = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
        bit_out = adj[3];
        digit_next = digit_reg;
        if (ctrl.load)
        begin
            digit_next = load_digit;
        end
        else if (ctrl.conv)
        begin
            digit_next = {adj[2:0], bit_in};
        end
        else if (ctrl.shift)
        begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    assign digit = digit_reg;

endmodule

/* test/i2a_text_checker.sv */
// checker for the binary to ascii text converter: predicts the text of each value and compares it
`timescale 1ns / 100ps

module i2a_text_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  logic               item_ready,
    input  i2a_pkg::in_item_t  item,
    input  logic               text_valid,
    input  logic               text_ready,
    input  i2a_pkg::out_item_t text,
    output int                 mismatches,
    output int                 pending,
    output int                 chars_checked
);

    localparam logic [63:0] RADIX_DEC = 64'd10;
    localparam logic [63:0] RADIX_HEX = 64'd16;
    localparam int REPORT_MAX = 10;

    i2a_pkg::out_item_t expected_text[$];
    i2a_pkg::out_item_t want;

    initial
    begin
        mismatches    = 0;
        pending       = 0;
        chars_checked = 0;
    end

    // queue the characters of one value, most significant first
    function automatic void push_expected_text(input i2a_pkg::in_item_t req);
        logic [63:0]        magnitude;
        logic [63:0]        radix;
        logic [63:0]        rem;
        logic [7:0]         digits[$];
        logic               negative;
        i2a_pkg::out_item_t ch;
        negative  = (req.req_type == i2a_pkg::REQ_DEC) && req.value[63];
        magnitude = negative ? (~req.value + 64'd1) : req.value;
        radix     = (req.req_type == i2a_pkg::REQ_HEX) ? RADIX_HEX : RADIX_DEC;
        do
        begin
            rem = magnitude % radix;
            if (rem < RADIX_DEC)
            begin
                digits.push_front(i2a_pkg::CH_ZERO + rem[7:0]);
            end
            else
            begin
                digits.push_front(i2a_pkg::CH_A + rem[7:0] - RADIX_DEC[7:0]);
            end
            magnitude = magnitude / radix;
        end
        while (magnitude != 64'd0);
        if (negative)
        begin
            digits.push_front(i2a_pkg::CH_MINUS);
        end
        foreach (digits[i])
        begin
            ch.char_code = digits[i];
            ch.last      = (i == digits.size() - 1);
            expected_text.push_back(ch);
        end
    endfunction

    function automatic void log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX)
        begin
            $display("mismatch at character %0d: %s", chars_checked, msg);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (text_valid && text_ready)
            begin
                chars_checked++;
                if (expected_text.size() == 0)
                begin
                    log_mismatch($sformatf("unexpected transaction, char 0x%02h last %0b",
                                           text.char_code, text.last));
                end
                else
                begin
                    want = expected_text.pop_front();
                    if (text.char_code !== want.char_code)
                    begin
                        log_mismatch($sformatf("char_code expected 0x%02h actual 0x%02h",
                                               want.char_code, text.char_code));
                    end
                    if (text.last !== want.last)
                    begin
                        log_mismatch($sformatf("last expected %0b actual %0b",
                                               want.last, text.last));
                    end
                end
            end
            if (item_valid && item_ready)
            begin
                push_expected_text(item);
            end
            pending = expected_text.size();
        end
    end

endmodule

/* test/testbench.sv */
// top of the converter testbench: clock, reset, stimulus, receiver stalls and verdict
`timescale 1ns / 100ps

module testbench;

    localparam int RANDOM_ITEMS = 470;
    localparam int CYCLE_LIMIT  = 4000000;
    localparam int HOLD_START   = 3000;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 150;

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_ready;
    i2a_pkg::in_item_t  item;
    logic               text_valid;
    logic               text_ready;
    i2a_pkg::out_item_t text;

    int mismatches;
    int pending;
    int chars_checked;
    int cycle_count = 0;
    int n_dec = 0;
    int n_hex = 0;
    int n_neg = 0;

    i2a_pkg::in_item_t directed_items[$];

    int64_to_ascii_hex_or_decimal_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .text_valid (text_valid),
        .text_ready (text_ready),
        .text       (text)
    );

    i2a_text_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .item          (item),
        .text_valid    (text_valid),
        .text_ready    (text_ready),
        .text          (text),
        .mismatches    (mismatches),
        .pending       (pending),
        .chars_checked (chars_checked)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timed out after %0d cycles, %0d characters still expected",
                     cycle_count, pending);
            $display("int64_to_ascii_hex_or_decimal_unit regression: fail");
            $finish;
        end
    end

    function automatic i2a_pkg::in_item_t make_item(input logic req, input logic [63:0] v);
        i2a_pkg::in_item_t t;
        t.req_type = req;
        t.value    = v;
        return t;
    endfunction

    // values spread over all text lengths, digit boundaries and signs
    function automatic logic [63:0] random_value();
        logic [63:0] v;
        logic [63:0] pw;
        int k;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1, 2, 3: ;
            4, 5, 6: v = v >> $urandom_range(1, 63);
            7: v = 64'($urandom_range(0, 100));
            8:
            begin
                pw = 64'd1;
                if ($urandom_range(0, 1) == 0)
                begin
                    k = $urandom_range(0, 19);
                    repeat (k) pw = pw * 64'd10;
                end
                else
                begin
                    pw = pw << (4 * $urandom_range(0, 15));
                end
                v = pw - 64'd1 + 64'($urandom_range(0, 2));
            end
            default: v = ~(v >> $urandom_range(1, 63));
        endcase
        return v;
    endfunction

    task automatic offer_item(input i2a_pkg::in_item_t t);
        int r;
        int gap;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            gap = 0;
        end
        else if (r < 92)
        begin
            gap = $urandom_range(1, 4);
        end
        else
        begin
            gap = $urandom_range(20, 150);
        end
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= t;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
        if (t.req_type == i2a_pkg::REQ_HEX)
        begin
            n_hex++;
        end
        else
        begin
            n_dec++;
            if (t.value[63])
            begin
                n_neg++;
            end
        end
    endtask

    // receiver: bursts of ready with short or long stalls, plus one long hold-off
    initial
    begin
        int run;
        int stall;
        int r;
        bit held;
        held = 1'b0;
        text_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
            repeat (run)
            begin
                text_ready <= 1'b1;
                @(posedge clk);
            end
            r = $urandom_range(0, 9);
            stall = (r < 7) ? $urandom_range(1, 3) : $urandom_range(10, 60);
            repeat (stall)
            begin
                text_ready <= 1'b0;
                @(posedge clk);
            end
            if (!held && cycle_count >= HOLD_START)
            begin
                held = 1'b1;
                repeat (HOLD_CYCLES)
                begin
                    text_ready <= 1'b0;
                    @(posedge clk);
                end
            end
        end
    end

    initial
    begin
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;

        directed_items.push_back(make_item(i2a_pkg::REQ_DEC, 64'd0));
        directed_items.push_back(make_item(i2a_pkg::REQ_HEX, 64'd0));
        directed_items.push_back(make_item(i2a_pkg::REQ_DEC, 64'd1));
        directed_items.push_back(make_item(i2a_pkg::REQ_DEC, 64'd9));
        directed_items.push_back(make_item(i2a_pkg::REQ_DEC, 64'd10));
        directed_items.push_back(make_item(i2a_pkg::REQ_DEC, 64'hFFFF_FFFF_FFFF_FFFF));
        directed_items.push_back(make_item(i2a_pkg::REQ_HEX, 64'hFFFF_FFFF_FFFF_FFFF));
        directed_items.push_back(make_item(i2a_pkg::REQ_DEC, 64'hFFFF_FFFF_FFFF_FFF6));
        directed_items.push_back(make_item(i2a_pkg::REQ_DEC, 64'h7FFF_FFFF_FFFF_FFFF));
        directed_items.push_back(make_item(i2a_pkg::REQ_HEX, 64'h7FFF_FFFF_FFFF_FFFF));
        directed_items.push_back(make_item(i2a_pkg::REQ_DEC, 64'h8000_0000_0000_0000));
        directed_items.push_back(make_item(i2a_pkg::REQ_HEX, 64'h8000_0000_0000_0000));
        directed_items.push_back(make_item(i2a_pkg::REQ_DEC, 64'h8000_0000_0000_0001));
        directed_items.push_back(make_item(i2a_pkg::REQ_HEX, 64'hF));
        directed_items.push_back(make_item(i2a_pkg::REQ_HEX, 64'h10));
        directed_items.push_back(make_item(i2a_pkg::REQ_DEC, 64'd999999999999999999));
        directed_items.push_back(make_item(i2a_pkg::REQ_DEC, 64'd1000000000000000000));
        directed_items.push_back(make_item(i2a_pkg::REQ_HEX, 64'h8AC7_2304_89E8_0000));
        directed_items.push_back(make_item(i2a_pkg::REQ_DEC, 64'h8AC7_2304_89E8_0000));
        directed_items.push_back(make_item(i2a_pkg::REQ_HEX, 64'h0123_4567_89AB_CDEF));
        directed_items.push_back(make_item(i2a_pkg::REQ_HEX, 64'hFEDC_BA98_7654_3210));
        directed_items.push_back(make_item(i2a_pkg::REQ_DEC, 64'hFEDC_BA98_7654_3210));
        directed_items.push_back(make_item(i2a_pkg::REQ_DEC, 64'h5555_5555_5555_5555));
        directed_items.push_back(make_item(i2a_pkg::REQ_HEX, 64'hAAAA_AAAA_AAAA_AAAA));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_items[i])
        begin
            offer_item(directed_items[i]);
        end
        repeat (RANDOM_ITEMS)
        begin
            offer_item(make_item(1'($urandom_range(0, 1)), random_value()));
        end
        item_valid <= 1'b0;
        @(posedge clk);

        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d values: %0d decimal (%0d negative) and %0d hex",
                 n_dec + n_hex, n_dec, n_neg, n_hex);
        $display("checked %0d characters with random gaps, stalls and a %0d-cycle hold-off",
                 chars_checked, HOLD_CYCLES);
        if (mismatches == 0 && pending == 0)
        begin
            $display("int64_to_ascii_hex_or_decimal_unit regression: pass");
        end
        else
        begin
            $display("int64_to_ascii_hex_or_decimal_unit regression: fail");
        end
        $finish;
    end

endmodule
